// ===== rtl/source_code_tokenizer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the source code tokenizer
// Implication checks on the rising clock edge, masked while reset is high.
// ----------------------------------------------------------------------------
`ifndef SOURCE_CODE_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_CODE_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer same-cycle check failed");

// Next-cycle implication.
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer next-cycle check failed");

`endif

// ===== rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Token kinds, scan modes, character tables and the keyword list.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

   localparam logic [6:0] K_OP0     = 7'd13;
   localparam logic [6:0] K_SLASH   = 7'd26;
   localparam logic [6:0] K_QQ      = 7'd47;
   localparam logic [6:0] K_QQEQ    = 7'd48;
   localparam logic [6:0] K_KW0     = 7'd49;
   localparam logic [6:0] K_IDENT   = 7'd79;
   localparam logic [6:0] K_INT     = 7'd80;
   localparam logic [6:0] K_FLOAT   = 7'd81;
   localparam logic [6:0] K_STRING  = 7'd82;
   localparam logic [6:0] K_COMMENT = 7'd83;
   localparam logic [6:0] K_ERROR   = 7'd84;
   localparam logic [6:0] K_EOF     = 7'd85;

   localparam int KW_COUNT = 30;
   localparam int KW_CHARS = 11;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);

   typedef enum logic [13:0] {
      M_IDLE     = 14'h0001,
      M_OP       = 14'h0002,
      M_QQ       = 14'h0004,
      M_SLASH    = 14'h0008,
      M_IDENT    = 14'h0010,
      M_NUM_INT  = 14'h0020,
      M_NUM_FRAC = 14'h0040,
      M_STRING   = 14'h0080,
      M_LC_LEAD  = 14'h0100,
      M_LC_BODY  = 14'h0200,
      M_BC_LEAD  = 14'h0400,
      M_BC_BODY  = 14'h0800,
      M_BC_SLASH = 14'h1000,
      M_BC_STAR  = 14'h2000
   } mode_type;

   typedef struct packed {
      logic [6:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic [15:0] col;
      logic        last;
   } token_type;

   localparam logic [7:0] SINGLE_CHARS [13] = '{
      "#", "@", "~", ";", "(", ")", "[", "]", "{", "}", "$", ",", "."};
   localparam logic [7:0] OP_CHARS [16] = '{
      "=", ":", "+", "-", "*", ">", "<", "^", "&", "|", "%", "!", "?",
      8'h00, 8'h00, 8'h00};
   localparam logic [6:0] OP_DOUBLE [16] = '{
      7'd27, 7'd28, 7'd30, 7'd32, 7'd34, 7'd36, 7'd38, 7'd0,
      7'd41, 7'd43, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
   localparam logic [6:0] OP_EQUAL [16] = '{
      7'd0, 7'd29, 7'd31, 7'd33, 7'd35, 7'd37, 7'd39, 7'd40,
      7'd42, 7'd44, 7'd45, 7'd46, 7'd0, 7'd0, 7'd0, 7'd0};
   localparam logic [3:0] OP_QUESTION = 4'd12;

   // Keyword text, right aligned: the last letter sits in bits 7:0.
   localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
      "if", "else", "while", "for", "unless", "break", "continue",
      "fallthrough", "struct", "enum", "as", "mut", "module", "use", "func",
      "return", "impl", "trait", "and", "or", "true", "false", "nil",
      "println", "switch", "case", "default", "defer", "union", "const"};
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd5, 4'd8, 4'd11, 4'd6, 4'd4,
      4'd2, 4'd3, 4'd6, 4'd3, 4'd4, 4'd6, 4'd4, 4'd5, 4'd3, 4'd2,
      4'd4, 4'd5, 4'd3, 4'd7, 4'd6, 4'd4, 4'd7, 4'd5, 4'd5, 4'd5};

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // Bit 4 flags a hit, bits 3:0 give the table index.
   function automatic logic [4:0] single_index(logic [7:0] c);
      logic [4:0] r;
      r = '0;
      for (int i = 12; i >= 0; i--) begin
         if (SINGLE_CHARS[i] == c) r = {1'b1, 4'(i)};
      end
      return r;
   endfunction

   function automatic logic [4:0] op_index(logic [7:0] c);
      logic [4:0] r;
      r = '0;
      for (int i = 12; i >= 0; i--) begin
         if (OP_CHARS[i] == c) r = {1'b1, 4'(i)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/source_code_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// source_code_tokenizer_unit
// Maximal-munch lexer: one source byte in per word, tokens out per word.
// ----------------------------------------------------------------------------
// Feed source text one byte per req word (tlast marks the final byte; a zero
// byte also ends the text). Each byte is scanned in the cycle it is taken, and
// the tokens it completes (none, one, two or three) land in a four-word result
// queue; rsp_tlast marks the last token caused by that byte. A byte is taken
// every cycle while the queue holds at most one word, so a byte-per-cycle
// stream runs at full rate as long as the consumer takes one token per cycle;
// a byte that completes several tokens holds the input while the single-word
// output port drains the queue back to one word. After end-of-file the
// scanner returns to its reset state and the next byte opens a new text at
// offset zero, line zero. Offsets, lengths, lines and columns saturate.
`default_nettype none
`include "source_code_tokenizer_unit_assert.svh"

module source_code_tokenizer_unit
   import sct_pkg::*;
#(
   parameter int POSITION_WIDTH  = 16,
   parameter int MAX_NESTING     = 15,
   parameter int KEYWORD_MAX_LEN = 11
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [6:0] token_kind, [22:7] start_offset,
                                         // [38:23] token_length, [54:39] line_number,
                                         // [70:55] column_number, [71] zero
   output logic             rsp_tlast    // last_of_run
);

   localparam int DW  = $clog2(MAX_NESTING + 1);
   localparam int WLW = $clog2(KEYWORD_MAX_LEN + 2);
   localparam int BW  = $clog2(KEYWORD_MAX_LEN);

   typedef logic [POSITION_WIDTH-1:0] pos_type;

   typedef struct packed {
      mode_type                         mode;
      pos_type                          pos;
      pos_type                          line;
      pos_type                          lstart;
      pos_type                          pstart;
      pos_type                          pline;
      pos_type                          pcol;
      pos_type                          lend;
      logic                             pfloat;
      logic [3:0]                       op_idx;
      logic [KEYWORD_MAX_LEN-1:0][7:0]  wbuf;
      logic [WLW-1:0]                   wlen;
      logic [DW-1:0]                    depth;
      logic                             esc;
   } scan_type;

   typedef struct packed {
      scan_type  s;
      logic      ev;
      token_type tk;
      logic      again;
   } pass_type;

   typedef struct packed {
      logic      pv;
      token_type pend;
      token_type eof;
   } fin_type;

   // ---------------------------------------------------------------- helpers
   function automatic pos_type sat_inc(pos_type v);
      return (&v) ? v : v + pos_type'(1);
   endfunction

   function automatic pos_type diff(pos_type a, pos_type b);
      return (a >= b) ? a - b : '0;
   endfunction

   function automatic pos_type col_of(pos_type p, scan_type s);
      return sat_inc(diff(p, s.lstart));
   endfunction

   function automatic logic [15:0] to16(pos_type v);
      logic [POSITION_WIDTH+15:0] w;
      w = {16'b0, v};
      return w[15:0];
   endfunction

   function automatic token_type mk(logic [6:0] kind, pos_type start, pos_type len,
                                    pos_type line, pos_type col);
      token_type t;
      t.kind  = kind;
      t.start = to16(start);
      t.len   = to16(len);
      t.line  = to16(line);
      t.col   = to16(col);
      t.last  = 1'b0;
      return t;
   endfunction

   function automatic token_type mk_pend(scan_type s, logic [6:0] kind, pos_type len);
      return mk(kind, s.pstart, len, s.pline, s.pcol);
   endfunction

   function automatic scan_type rst_state();
      scan_type s;
      s      = '0;
      s.mode = M_IDLE;
      s.pcol = pos_type'(1);
      return s;
   endfunction

   // Exact keyword match against the word buffer.
   function automatic logic [6:0] word_kind(scan_type s);
      logic [6:0] k;
      logic       hit;
      logic       eq;
      int         sh;
      k   = K_IDENT;
      hit = 1'b0;
      if (s.wlen <= WLW'(KEYWORD_MAX_LEN)) begin
         for (int i = 0; i < KW_COUNT; i++) begin
            eq = (s.wlen == WLW'(KW_LEN[i]));
            for (int j = 0; j < KW_CHARS; j++) begin
               sh = 8 * (int'(KW_LEN[i]) - 1 - j);
               if (j < int'(KW_LEN[i]) && s.wbuf[j] != KW_TEXT[i][sh +: 8]) eq = 1'b0;
            end
            if (eq && !hit) begin
               hit = 1'b1;
               k   = K_KW0 + 7'(i);
            end
         end
      end
      return k;
   endfunction

   function automatic logic [6:0] num_kind(scan_type s);
      return s.pfloat ? K_FLOAT : K_INT;
   endfunction

   // One scan pass over byte c; again asks for a rescan in the mode the pass left.
   function automatic pass_type handle(scan_type s, logic [7:0] c);
      pass_type   r;
      logic [4:0] si;
      logic [4:0] oi;
      pos_type    p;
      p       = s.pos;
      si      = single_index(c);
      oi      = op_index(c);
      r.s     = s;
      r.ev    = 1'b0;
      r.tk    = '0;
      r.again = 1'b0;
      unique case (s.mode)
         M_OP: begin
            r.s.mode = M_IDLE;
            if (s.op_idx == OP_QUESTION && c == "?") begin
               r.s.mode = M_QQ;
            end else if (c == OP_CHARS[s.op_idx] && OP_DOUBLE[s.op_idx] != 7'd0) begin
               r.ev = 1'b1;
               r.tk = mk_pend(s, OP_DOUBLE[s.op_idx], pos_type'(2));
            end else if (c == "=" && OP_EQUAL[s.op_idx] != 7'd0) begin
               r.ev = 1'b1;
               r.tk = mk_pend(s, OP_EQUAL[s.op_idx], pos_type'(2));
            end else begin
               r.ev    = 1'b1;
               r.tk    = mk_pend(s, K_OP0 + {3'b0, s.op_idx}, pos_type'(1));
               r.again = 1'b1;
            end
         end
         M_QQ: begin
            r.s.mode = M_IDLE;
            r.ev     = 1'b1;
            if (c == "=") begin
               r.tk = mk_pend(s, K_QQEQ, pos_type'(3));
            end else begin
               r.tk    = mk_pend(s, K_QQ, pos_type'(2));
               r.again = 1'b1;
            end
         end
         M_SLASH: begin
            if (c == "/") begin
               r.s.mode = M_LC_LEAD;
            end else if (c == "*") begin
               r.s.mode  = M_BC_LEAD;
               r.s.depth = DW'(1);
            end else begin
               r.s.mode = M_IDLE;
               r.ev     = 1'b1;
               r.tk     = mk_pend(s, K_SLASH, pos_type'(1));
               r.again  = 1'b1;
            end
         end
         M_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == "_") begin
               if (s.wlen < WLW'(KEYWORD_MAX_LEN)) r.s.wbuf[s.wlen[BW-1:0]] = c;
               if (s.wlen <= WLW'(KEYWORD_MAX_LEN)) r.s.wlen = s.wlen + WLW'(1);
            end else begin
               r.s.mode = M_IDLE;
               r.ev     = 1'b1;
               r.tk     = mk_pend(s, word_kind(s), diff(p, s.pstart));
               r.again  = 1'b1;
            end
         end
         M_NUM_INT: begin
            if (is_digit(c)) begin
               r.s.mode = M_NUM_INT;
            end else if (c == "x" || c == "b" || c == "o" || c == ".") begin
               r.s.pfloat = (c == ".");
               r.s.mode   = M_NUM_FRAC;
            end else begin
               r.s.mode = M_IDLE;
               r.ev     = 1'b1;
               r.tk     = mk_pend(s, num_kind(s), diff(p, s.pstart));
               r.again  = 1'b1;
            end
         end
         M_NUM_FRAC: begin
            if (!is_digit(c)) begin
               r.s.mode = M_IDLE;
               r.ev     = 1'b1;
               r.tk     = mk_pend(s, num_kind(s), diff(p, s.pstart));
               r.again  = 1'b1;
            end
         end
         M_STRING: begin
            if (s.esc) begin
               r.s.esc = 1'b0;
            end else if (c == "\\") begin
               r.s.esc = 1'b1;
            end else if (c == "\"") begin
               r.s.mode = M_IDLE;
               r.ev     = 1'b1;
               r.tk     = mk_pend(s, K_STRING, diff(p, s.pstart));
            end
         end
         M_LC_LEAD: begin
            if (c == "\n") begin
               r.s.pstart = p;
               r.s.lend   = p;
               r.s.mode   = M_IDLE;
               r.ev       = 1'b1;
               r.tk       = mk_pend(r.s, K_COMMENT, '0);
            end else if (!is_space(c)) begin
               r.s.pstart = p;
               r.s.lend   = sat_inc(p);
               r.s.mode   = M_LC_BODY;
            end
         end
         M_LC_BODY: begin
            if (c == "\n") begin
               r.s.mode = M_IDLE;
               r.ev     = 1'b1;
               r.tk     = mk_pend(s, K_COMMENT, diff(s.lend, s.pstart));
            end else if (!is_space(c)) begin
               r.s.lend = sat_inc(p);
            end
         end
         M_BC_LEAD: begin
            if (!is_space(c)) begin
               r.s.pstart = p;
               r.s.lend   = p;
               r.s.mode   = M_BC_BODY;
               r.again    = 1'b1;
            end
         end
         M_BC_BODY: begin
            if (c == "/") begin
               r.s.lend = sat_inc(p);
               r.s.mode = M_BC_SLASH;
            end else if (c == "*") begin
               r.s.mode = M_BC_STAR;
            end else if (!is_space(c)) begin
               r.s.lend = sat_inc(p);
            end
         end
         M_BC_SLASH: begin
            r.s.mode = M_BC_BODY;
            if (c == "*") begin
               if (s.depth < DW'(MAX_NESTING)) r.s.depth = s.depth + DW'(1);
               r.s.lend = sat_inc(p);
            end else begin
               r.again = 1'b1;
            end
         end
         M_BC_STAR: begin
            if (c == "/") begin
               if (s.depth <= DW'(1)) begin
                  r.s.depth = '0;
                  r.s.mode  = M_IDLE;
                  r.ev      = 1'b1;
                  r.tk      = mk_pend(s, K_COMMENT, diff(s.lend, s.pstart));
               end else begin
                  r.s.depth = s.depth - DW'(1);
                  r.s.lend  = sat_inc(p);
                  r.s.mode  = M_BC_BODY;
               end
            end else begin
               r.s.lend = p;
               r.s.mode = M_BC_BODY;
               r.again  = 1'b1;
            end
         end
         default: begin
            // Idle: skip whitespace, open a token or emit a one-byte one.
            r.s.mode = M_IDLE;
            if (is_space(c)) begin
               r.s.mode = M_IDLE;
            end else if (si[4]) begin
               r.ev = 1'b1;
               r.tk = mk({3'b0, si[3:0]}, p, pos_type'(1), s.line, col_of(p, s));
            end else begin
               r.s.pstart = p;
               r.s.pline  = s.line;
               r.s.pcol   = col_of(p, s);
               if (oi[4]) begin
                  r.s.op_idx = oi[3:0];
                  r.s.mode   = M_OP;
               end else if (c == "/") begin
                  r.s.mode = M_SLASH;
               end else if (c == "\"") begin
                  r.s.pstart = sat_inc(p);
                  r.s.esc    = 1'b0;
                  r.s.mode   = M_STRING;
               end else if (is_alpha(c) || c == "_") begin
                  r.s.wbuf[0] = c;
                  r.s.wlen    = WLW'(1);
                  r.s.mode    = M_IDENT;
               end else if (is_digit(c)) begin
                  r.s.pfloat = 1'b0;
                  r.s.mode   = M_NUM_INT;
               end else begin
                  r.ev = 1'b1;
                  r.tk = mk(K_ERROR, p, pos_type'(1), s.line, col_of(p, s));
               end
            end
         end
      endcase
      return r;
   endfunction

   // Flush the open token at end of text and build the end-of-file token.
   function automatic fin_type finish(scan_type s);
      fin_type f;
      pos_type q;
      q      = s.pos;
      f.pv   = 1'b1;
      f.pend = '0;
      unique case (s.mode)
         M_OP:       f.pend = mk_pend(s, K_OP0 + {3'b0, s.op_idx}, pos_type'(1));
         M_QQ:       f.pend = mk_pend(s, K_QQ, pos_type'(2));
         M_SLASH:    f.pend = mk_pend(s, K_SLASH, pos_type'(1));
         M_IDENT:    f.pend = mk_pend(s, word_kind(s), diff(q, s.pstart));
         M_NUM_INT,
         M_NUM_FRAC: f.pend = mk_pend(s, num_kind(s), diff(q, s.pstart));
         M_STRING:   f.pend = mk_pend(s, K_STRING, diff(q, s.pstart));
         M_LC_LEAD,
         M_BC_LEAD:  f.pend = mk(K_COMMENT, q, '0, s.pline, s.pcol);
         M_BC_STAR:  f.pend = mk_pend(s, K_COMMENT, diff(q, s.pstart));
         M_LC_BODY,
         M_BC_BODY,
         M_BC_SLASH: f.pend = mk_pend(s, K_COMMENT, diff(s.lend, s.pstart));
         default:    f.pv   = 1'b0;
      endcase
      f.eof = mk(K_EOF, q, '0, s.line, col_of(q, s));
      return f;
   endfunction

   // ---------------------------------------------------------------- datapath
   scan_type              st_ff, st_in;
   token_type             fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]    rd_ff, wr_ff;
   logic [FIFO_AW:0]      cnt_ff, cnt_in;

   logic [7:0]  c;
   logic        eoi;
   logic        accept, pop, ends;
   pass_type    p1, p2;
   scan_type    s_h, s_u, s_fin;
   fin_type     fin;
   logic        cv [4];
   token_type   ct [4];
   token_type   outs [4];
   logic [1:0]  n;

   assign c      = req_tdata;
   assign eoi    = req_tlast;
   assign ends   = (c == 8'h00) || eoi;
   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   // Room for the largest burst a byte can cause.
   assign req_tready = cnt_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 3);
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = {1'b0, fifo_ff[rd_ff].col, fifo_ff[rd_ff].line,
                        fifo_ff[rd_ff].len, fifo_ff[rd_ff].start, fifo_ff[rd_ff].kind};
   assign rsp_tlast  = fifo_ff[rd_ff].last;

   always_comb begin
      // First pass, then at most one rescan in the mode the first pass left.
      p1  = handle(st_ff, c);
      p2  = handle(p1.s, c);
      s_h = p1.again ? p2.s : p1.s;

      // Advance position and line bookkeeping.
      s_u     = s_h;
      s_u.pos = sat_inc(st_ff.pos);
      if (c == "\n") begin
         s_u.line   = sat_inc(st_ff.line);
         s_u.lstart = s_u.pos;
      end

      s_fin = (c == 8'h00) ? st_ff : s_u;
      fin   = finish(s_fin);

      cv[0] = (c != 8'h00) && p1.ev;
      ct[0] = p1.tk;
      cv[1] = (c != 8'h00) && p1.again && p2.ev;
      ct[1] = p2.tk;
      cv[2] = ends && fin.pv;
      ct[2] = fin.pend;
      cv[3] = ends;
      ct[3] = fin.eof;

      st_in = ends ? rst_state() : s_u;
   end

   // Pack the produced tokens in order and tag the last one.
   always_comb begin
      n = '0;
      for (int i = 0; i < 4; i++) outs[i] = '0;
      for (int i = 0; i < 4; i++) begin
         if (cv[i] && n != 2'd3) begin
            outs[n] = ct[i];
            n       = n + 2'd1;
         end
      end
      if (n != '0) outs[n - 2'd1].last = 1'b1;
   end

   always_comb begin
      cnt_in = cnt_ff - {{FIFO_AW{1'b0}}, pop};
      if (accept) cnt_in = cnt_in + (FIFO_AW+1)'(n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= rst_state();
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (accept) begin
            st_ff <= st_in;
            wr_ff <= wr_ff + FIFO_AW'(n);
         end
         if (pop) rd_ff <= rd_ff + FIFO_AW'(1);
         cnt_ff <= cnt_in;
      end
   end

   // Result queue payload: write the burst at consecutive slots.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (accept && 2'(i) < n) fifo_ff[wr_ff + FIFO_AW'(i)] <= outs[i];
      end
   end

   // ---------------------------------------------------------------- checks
   `SCT_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, cnt_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
   `SCT_ASSERT_NOW(a_idle_depth, clock, reset, st_ff.mode == M_IDLE, st_ff.depth == '0)
   `SCT_ASSERT_NEXT(a_eof_restart, clock, reset, accept && c == 8'h00, st_ff.mode == M_IDLE && st_ff.pos == '0)
   `SCT_ASSERT_NEXT(a_eof_queued, clock, reset, accept && ends, cnt_ff != '0)

endmodule

`default_nettype wire
